@@ rtl/ilte_pkg.sv @@
package ilte_pkg;

	localparam int unsigned DEF_ENTRIES    = 64;
	localparam int unsigned DEF_ENTRY_BITS = 32;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CAP_W    = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_POP    = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FINISH
	} state_t;

endpackage

@@ rtl/indexed_list_table_engine.sv @@
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_valid/cfg_ready  cfg_data (capacity limit)
// in        in         in_valid/in_stall    command, position, value_in
// out       out        out_valid/out_stall  status, value_out, count
//
// One request at a time. Append and any rejected request go from acceptance straight to
// the finish state. Pop, insert and remove first pass through the shift state, insert and
// remove with a one-word-per-cycle move through the entry RAM (one read, one write a cycle).
// Reset clears the count and the control state; RAM contents stay undefined.
// A stalled result sits in the output register; the next request is taken meanwhile
// and waits for the output register before it completes.
module indexed_list_table_engine #(
	parameter int unsigned ENTRIES    = ilte_pkg::DEF_ENTRIES,
	parameter int unsigned ENTRY_BITS = ilte_pkg::DEF_ENTRY_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ilte_pkg::CAP_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ilte_pkg::CMD_W-1:0]    command,
	input  logic [ilte_pkg::POS_W-1:0]    position,
	input  logic [ilte_pkg::VAL_W-1:0]    value_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ilte_pkg::STATUS_W-1:0] status,
	output logic [ilte_pkg::VAL_W-1:0]    value_out,
	output logic [ilte_pkg::CAP_W-1:0]    count
);

	import ilte_pkg::*;

	localparam int unsigned AW    = $clog2(ENTRIES);
	localparam int unsigned CW    = $clog2(ENTRIES + 1);
	localparam int unsigned CMPW  = (CW > CAP_W) ? CW : CAP_W;
	localparam int unsigned EXT_W = (ENTRY_BITS > VAL_W) ? ENTRY_BITS : VAL_W;

	state_t state_q, state_d;

	logic [CW-1:0]         count_q;
	logic [CAP_W-1:0]      cap_q;
	cmd_t                  cmd_q;
	logic [AW-1:0]         pos_q;
	logic [ENTRY_BITS-1:0] val_q;
	status_t               status_q;
	logic [ENTRY_BITS-1:0] result_q;
	logic [AW-1:0]         rd_addr_q;
	logic [CW-1:0]         rd_left_q;
	logic                  first_q;
	logic                  pend_q;
	logic                  pend_first_q;
	logic [AW-1:0]         pend_addr_q;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [VAL_W-1:0]      out_value_q;
	logic [CAP_W-1:0]      out_count_q;

	cmd_t                  cmd_in;
	status_t               req_status;
	logic                  in_acc;
	logic                  needs_shift;
	logic                  is_full;
	logic                  pos_bad;
	logic                  out_load;
	logic [CMPW-1:0]       count_ext;
	logic [CMPW-1:0]       cap_ext;
	logic [CMPW-1:0]       pos_ext;
	logic [EXT_W-1:0]      in_ext;
	logic [EXT_W-1:0]      result_ext;
	logic [ENTRY_BITS-1:0] wval;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [ENTRY_BITS-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [ENTRY_BITS-1:0] ram_rdata;

	ilte_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cmd_in     = cmd_t'(command);
	assign count_ext  = CMPW'(count_q);
	assign cap_ext    = CMPW'(cap_q);
	assign pos_ext    = CMPW'(position);
	assign in_ext     = EXT_W'(value_in);
	assign wval       = in_ext[ENTRY_BITS-1:0];
	assign result_ext = EXT_W'(result_q);

	assign is_full = (count_ext >= cap_ext) || (count_ext >= CMPW'(ENTRIES));
	assign pos_bad = pos_ext >= count_ext;
	assign in_acc  = in_valid && !in_stall;

	always_comb begin
		unique case (cmd_in)
			CMD_APPEND: req_status = is_full ? STAT_FULL : STAT_OK;
			CMD_POP:    req_status = (count_q == '0) ? STAT_EMPTY : STAT_OK;
			CMD_INSERT: req_status = pos_bad ? STAT_RANGE : (is_full ? STAT_FULL : STAT_OK);
			CMD_REMOVE: req_status = pos_bad ? STAT_RANGE : STAT_OK;
		endcase
	end

	assign needs_shift = (req_status == STAT_OK) && (cmd_in != CMD_APPEND);
	assign out_load    = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = needs_shift ? ST_SHIFT : ST_FINISH;
				end
			end
			ST_SHIFT: begin
				if (rd_left_q == '0 && !pend_q) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM control and input handshake
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = rd_addr_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && cmd_in == CMD_APPEND && req_status == STAT_OK) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(count_q);
					ram_wdata = wval;
				end
			end
			ST_SHIFT: begin
				// word read last cycle moves one slot; the first read of a pop or remove is the result
				if (pend_q && !pend_first_q) begin
					ram_we    = 1'b1;
					ram_waddr = (cmd_q == CMD_INSERT) ? pend_addr_q + AW'(1)
					                                  : pend_addr_q - AW'(1);
				end
				if (rd_left_q != '0) begin
					ram_re = 1'b1;
				end
				if (rd_left_q == '0 && !pend_q && cmd_q == CMD_INSERT) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q;
					ram_wdata = val_q;
				end
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			rd_left_q   <= '0;
			first_q     <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					pend_q <= 1'b0;
					if (in_acc) begin
						rd_left_q <= '0;
						first_q   <= 1'b0;
						if (req_status == STAT_OK) begin
							unique case (cmd_in)
								CMD_APPEND: count_q <= count_q + CW'(1);
								CMD_INSERT: count_q <= count_q + CW'(1);
								CMD_POP:    count_q <= count_q - CW'(1);
								CMD_REMOVE: count_q <= count_q - CW'(1);
							endcase
						end
						if (needs_shift) begin
							rd_left_q <= (cmd_in == CMD_POP) ? CW'(1)
							                                 : CW'(count_ext - pos_ext);
							first_q   <= (cmd_in == CMD_POP) || (cmd_in == CMD_REMOVE);
						end
					end
				end
				ST_SHIFT: begin
					pend_q <= (rd_left_q != '0);
					if (rd_left_q != '0) begin
						rd_left_q <= rd_left_q - CW'(1);
						first_q   <= 1'b0;
					end
				end
				ST_FINISH: begin
					pend_q <= 1'b0;
				end
				default: begin
					pend_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			cmd_q     <= cmd_in;
			pos_q     <= AW'(position);
			val_q     <= wval;
			status_q  <= req_status;
			result_q  <= '0;
			rd_addr_q <= (cmd_in == CMD_REMOVE) ? AW'(position) : AW'(count_q - CW'(1));
		end
		if (state_q == ST_SHIFT) begin
			if (rd_left_q != '0) begin
				pend_addr_q  <= rd_addr_q;
				pend_first_q <= first_q;
				// insert walks down from the tail, remove walks up from the position
				rd_addr_q    <= (cmd_q == CMD_REMOVE) ? rd_addr_q + AW'(1) : rd_addr_q - AW'(1);
			end
			if (pend_q && pend_first_q) begin
				result_q <= ram_rdata;
			end
		end
		if (out_load) begin
			out_status_q <= status_q;
			out_value_q  <= result_ext[VAL_W-1:0];
			out_count_q  <= count_ext[CAP_W-1:0];
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign value_out = out_value_q;
	assign count     = out_count_q;

endmodule

@@ rtl/ilte_ram.sv @@
module ilte_ram #(
	parameter int unsigned WIDTH = ilte_pkg::DEF_ENTRY_BITS,
	parameter int unsigned DEPTH = ilte_pkg::DEF_ENTRIES
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/ilte_checker.sv @@
module ilte_checker #(
	parameter int unsigned ENTRIES = ilte_pkg::DEF_ENTRIES
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [ilte_pkg::STATUS_W-1:0] status,
	input logic [ilte_pkg::VAL_W-1:0]    value_out,
	input logic [ilte_pkg::CAP_W-1:0]    count
);

	import ilte_pkg::*;

	localparam int unsigned CHK_W = (CAP_W > 14) ? CAP_W : 14;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> value_out == '0)
		else $error("rejected request returned data");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> count == '0)
		else $error("empty status with entries held");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> CHK_W'(count) <= CHK_W'(ENTRIES))
		else $error("count above entry depth");

endmodule

bind indexed_list_table_engine ilte_checker #(
	.ENTRIES(ENTRIES)
) u_ilte_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.status   (status),
	.value_out(value_out),
	.count    (count)
);
